// ===== rtl/atsd_pkg.sv =====
// shared types and constants for the accelerometer tap shot detector
package atsd_pkg;

    localparam int HIST_LEN       = 5;
    localparam int THR_BITS       = 28;
    localparam int THR_SQ_BITS    = 14;
    localparam int ENERGY_BITS    = 29;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [16:0] THRESH_BASE = 17'd100000;
    localparam logic [13:0] THRESH_STEP = 14'd10000;
    localparam logic [31:0] PTP_LIMIT   = 32'd2000;

    localparam logic [2:0] WARM_LEN = 3'd5;
    localparam logic [7:0] RUN_CAP  = 8'd3;
    localparam logic [7:0] RUN_MAX  = 8'd255;

    localparam logic [6:0]             REFR_START      = 7'd50;
    localparam logic [6:0]             REFR_CFG_RESET  = 7'd33;
    localparam logic [THR_SQ_BITS-1:0] THR_SQ_RESET    = 14'd2500;
    localparam logic [ENERGY_BITS-1:0] ENERGY_MAX      = '1;

    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REFRACTORY = 4'd1;

    typedef struct packed {
        logic hist_shift;
        logic shot;
        logic energy_valid;
    } ctrl_t;

endpackage

// ===== rtl/accel_tap_shot_detector_core.sv =====
// top level of the accelerometer tap shot detector
// an accepted request is held in the input register, then its result in the result register
// throughput: one request per cycle while results are taken, set by the single detect stage and its state loop
// an output register decouples the sides, so a request can still enter the input register while a result waits
// reset: async active low, clears control, counters, refractory to 50, config to defaults
module accel_tap_shot_detector_core #(
    parameter int SAMPLE_BITS = 13,
    parameter int COUNT_BITS  = 20
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    func,
    input  logic signed [SAMPLE_BITS-1:0]           accel_x,
    input  logic signed [SAMPLE_BITS-1:0]           accel_y,
    input  logic signed [SAMPLE_BITS-1:0]           accel_z,
    input  logic                                    batch_end,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    shot_detected,
    output logic [COUNT_BITS-1:0]                   shot_count,
    output logic [atsd_pkg::ENERGY_BITS-1:0]        energy,
    output logic                                    energy_valid,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [atsd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [atsd_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int HL = atsd_pkg::HIST_LEN;
    localparam int TB = 2 * SAMPLE_BITS + 4;
    localparam int EB = 2 * SAMPLE_BITS + 6;

    logic                              s1_valid_reg;
    logic                              func_reg;
    logic                              batch_end_reg;
    logic signed [SAMPLE_BITS-1:0]     sample_reg [3];
    logic signed [SAMPLE_BITS-1:0]     hist_reg   [3][HL-1];
    logic signed [SAMPLE_BITS-1:0]     win        [3][HL];

    logic [atsd_pkg::THR_SQ_BITS-1:0]  thr_sq_reg;
    logic [6:0]                        refr_cfg_reg;

    logic                              out_valid_reg;
    logic                              shot_reg;
    logic [COUNT_BITS-1:0]             count_reg;
    logic [atsd_pkg::ENERGY_BITS-1:0]  energy_reg;
    logic                              energy_valid_reg;

    logic                              in_fire;
    logic                              s1_fire;
    logic [TB-1:0]                     term   [3];
    logic                              ptp_ok [3];
    logic [EB-1:0]                     energy_sum;
    atsd_pkg::ctrl_t                   ctrl;
    logic [COUNT_BITS-1:0]             count_new;
    logic [atsd_pkg::ENERGY_BITS-1:0]  energy_new;

    assign s1_fire   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg      <= func;
            batch_end_reg <= batch_end;
            sample_reg[0] <= accel_x;
            sample_reg[1] <= accel_y;
            sample_reg[2] <= accel_z;
        end
    end

    // config registers, threshold kept as s squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_sq_reg   <= atsd_pkg::THR_SQ_RESET;
            refr_cfg_reg <= atsd_pkg::REFR_CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == atsd_pkg::REG_THRESHOLD)
                thr_sq_reg <= atsd_pkg::THR_SQ_BITS'(cfg_data)
                            * atsd_pkg::THR_SQ_BITS'(cfg_data);
            else if (cfg_index == atsd_pkg::REG_REFRACTORY)
                refr_cfg_reg <= cfg_data;
        end
    end

    // sample history, oldest at index 0
    always_ff @(posedge clk)
    begin
        if (s1_fire && ctrl.hist_shift)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int k = 0; k < HL - 2; k++)
                    hist_reg[a][k] <= hist_reg[a][k+1];
                hist_reg[a][HL-2] <= sample_reg[a];
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < HL - 1; k++)
                win[a][k] = hist_reg[a][k];
            win[a][HL-1] = sample_reg[a];
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        atsd_axis #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_axis (
            .window (win[a]),
            .term   (term[a]),
            .ptp_ok (ptp_ok[a])
        );
    end

    assign energy_sum = EB'(term[0]) + EB'(term[1]) + EB'(term[2]);

    atsd_decide #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (s1_fire),
        .func       (func_reg),
        .batch_end  (batch_end_reg),
        .energy_sum (energy_sum),
        .ptp_ok     (ptp_ok[0] || ptp_ok[1] || ptp_ok[2]),
        .thr_sq     (thr_sq_reg),
        .refr_load  (refr_cfg_reg),
        .ctrl       (ctrl),
        .count      (count_new),
        .energy_out (energy_new)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            shot_reg         <= ctrl.shot;
            count_reg        <= count_new;
            energy_reg       <= energy_new;
            energy_valid_reg <= ctrl.energy_valid;
        end
    end

    assign out_valid     = out_valid_reg;
    assign shot_detected = shot_reg;
    assign shot_count    = count_reg;
    assign energy        = energy_reg;
    assign energy_valid  = energy_valid_reg;

    // a shot only comes from a sample whose energy was computed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && shot_reg |-> energy_valid_reg)
        else $error("shot without computed energy");

    // energy reads zero when not computed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !energy_valid_reg |-> energy_reg == '0)
        else $error("energy nonzero without valid");

    // a stalled request stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(func_reg))
        else $error("stalled request lost");

endmodule

// ===== rtl/atsd_axis.sv =====
// per-axis kernel filter, squared energy term and peak-to-peak check
module atsd_axis #(
    parameter int SAMPLE_BITS = 13
) (
    input  logic signed [SAMPLE_BITS-1:0] window [atsd_pkg::HIST_LEN],
    output logic        [2*SAMPLE_BITS+3:0] term,
    output logic                            ptp_ok
);

    localparam int FB = SAMPLE_BITS + 4;

    logic signed [FB-1:0]          filt;
    logic signed [2*FB-1:0]        prod;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic        [SAMPLE_BITS:0]   ptp;

    // kernel -1 -2 6 -2 -1, oldest first
    always_comb
    begin
        filt = (FB'(window[2]) <<< 2) + (FB'(window[2]) <<< 1)
             - (FB'(window[1]) <<< 1) - (FB'(window[3]) <<< 1)
             - FB'(window[0]) - FB'(window[4]);
        prod = filt * filt;
        term = prod[2*FB-1:4];
    end

    always_comb
    begin
        lo = window[0];
        hi = window[0];
        for (int k = 1; k < atsd_pkg::HIST_LEN; k++)
        begin
            if (window[k] < lo)
                lo = window[k];
            if (window[k] > hi)
                hi = window[k];
        end
        ptp    = (SAMPLE_BITS + 1)'(hi) - (SAMPLE_BITS + 1)'(lo);
        ptp_ok = 32'(ptp) >= atsd_pkg::PTP_LIMIT;
    end

endmodule

// ===== rtl/atsd_decide.sv =====
// detection state, threshold compare and shot counting
module atsd_decide #(
    parameter int SAMPLE_BITS = 13,
    parameter int COUNT_BITS  = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  logic                                 func,
    input  logic                                 batch_end,
    input  logic [2*SAMPLE_BITS+5:0]             energy_sum,
    input  logic                                 ptp_ok,
    input  logic [atsd_pkg::THR_SQ_BITS-1:0]     thr_sq,
    input  logic [6:0]                           refr_load,
    output atsd_pkg::ctrl_t                      ctrl,
    output logic [COUNT_BITS-1:0]                count,
    output logic [atsd_pkg::ENERGY_BITS-1:0]     energy_out
);

    localparam int EB = 2 * SAMPLE_BITS + 6;
    localparam int CW = (EB > atsd_pkg::ENERGY_BITS) ? EB : atsd_pkg::ENERGY_BITS;

    logic [2:0]            warm_reg, warm_next;
    logic [6:0]            refr_reg, refr_next;
    logic [7:0]            run_reg, run_next;
    logic                  drop_reg, drop_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic [atsd_pkg::THR_BITS-1:0] thresh;
    logic [CW-1:0]                 e_w;
    logic [CW-1:0]                 t_w;
    logic [CW-1:0]                 low_w;

    always_comb
    begin
        thresh = atsd_pkg::THR_BITS'(atsd_pkg::THRESH_BASE)
               + atsd_pkg::THR_BITS'(thr_sq) * atsd_pkg::THR_BITS'(atsd_pkg::THRESH_STEP);
        e_w    = CW'(energy_sum);
        t_w    = CW'(thresh);
        low_w  = CW'(thresh >> 3);
    end

    always_comb
    begin
        warm_next  = warm_reg;
        refr_next  = refr_reg;
        run_next   = run_reg;
        drop_next  = drop_reg;
        count_next = count_reg;
        ctrl       = '0;
        energy_out = '0;
        if (func == atsd_pkg::FUNC_CLEAR)
        begin
            count_next = '0;
        end
        else if (drop_reg)
        begin
            if (batch_end)
                drop_next = 1'b0;
        end
        else
        begin
            ctrl.hist_shift = 1'b1;
            if (warm_reg < atsd_pkg::WARM_LEN)
            begin
                warm_next = warm_reg + 3'd1;
            end
            else if (refr_reg != 7'd0)
            begin
                refr_next = refr_reg - 7'd1;
            end
            else
            begin
                ctrl.energy_valid = 1'b1;
                energy_out = (e_w > CW'(atsd_pkg::ENERGY_MAX)) ? atsd_pkg::ENERGY_MAX
                                                               : e_w[atsd_pkg::ENERGY_BITS-1:0];
                if (e_w >= low_w)
                    run_next = (run_reg == atsd_pkg::RUN_MAX) ? run_reg : run_reg + 8'd1;
                else
                    run_next = 8'd0;
                if (e_w >= t_w && ptp_ok && run_next <= atsd_pkg::RUN_CAP)
                begin
                    ctrl.shot = 1'b1;
                    if (count_reg != {COUNT_BITS{1'b1}})
                        count_next = count_reg + COUNT_BITS'(1);
                    refr_next = refr_load;
                    run_next  = 8'd0;
                    drop_next = !batch_end;
                end
            end
        end
        count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg  <= '0;
            refr_reg  <= atsd_pkg::REFR_START;
            run_reg   <= '0;
            drop_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            warm_reg  <= warm_next;
            refr_reg  <= refr_next;
            run_reg   <= run_next;
            drop_reg  <= drop_next;
            count_reg <= count_next;
        end
    end

    // a shot reloads the refractory countdown and restarts the run
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && ctrl.shot |=> refr_reg == $past(refr_load) && run_reg == 8'd0)
        else $error("shot did not reload refractory state");

    // clear request empties the shot total
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && func == atsd_pkg::FUNC_CLEAR |=> count_reg == '0)
        else $error("clear request left shot total nonzero");

endmodule

// ===== tb/atsd_checker.sv =====
`timescale 1ns / 100ps
// checker for the tap shot detector: tracks detector state, predicts each result, compares
module atsd_checker #(
    parameter int SAMPLE_BITS = 13,
    parameter int COUNT_BITS  = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                func,
    input  logic signed [SAMPLE_BITS-1:0]       accel_x,
    input  logic signed [SAMPLE_BITS-1:0]       accel_y,
    input  logic signed [SAMPLE_BITS-1:0]       accel_z,
    input  logic                                batch_end,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                shot_detected,
    input  logic [COUNT_BITS-1:0]               shot_count,
    input  logic [atsd_pkg::ENERGY_BITS-1:0]    energy,
    input  logic                                energy_valid,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [atsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [atsd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  results_due,
    output int                                  shots_seen,
    output int                                  energies_seen
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [atsd_pkg::CFG_DATA_BITS-1:0] THR_SET_RESET = 7'd50;

    typedef struct packed {
        logic                             shot;
        logic [COUNT_BITS-1:0]            count;
        logic [atsd_pkg::ENERGY_BITS-1:0] energy;
        logic                             evalid;
    } tap_report_t;

    int                     hist [atsd_pkg::HIST_LEN][3];
    int                     warm_cnt;
    int                     refr_left;
    int                     cand_run;
    bit                     drop_batch;
    logic [COUNT_BITS-1:0]  shot_total;
    logic [atsd_pkg::CFG_DATA_BITS-1:0] thr_set;
    logic [atsd_pkg::CFG_DATA_BITS-1:0] refr_set;
    tap_report_t            reports_due [$];
    int                     mismatches;
    int                     shot_tally;
    int                     energy_tally;

    function automatic tap_report_t detect_tap(input logic f, input int ax, input int ay,
                                               input int az, input logic be);
        tap_report_t rep;
        longint      acc;
        longint      e;
        longint      t;
        longint      ptp;
        longint      lo;
        longint      hi;
        int          s;
        int          a;
        int          k;
        rep = '0;
        if (f == atsd_pkg::FUNC_CLEAR) begin
            shot_total = '0;
        end else if (drop_batch) begin
            if (be)
                drop_batch = 1'b0;
        end else begin
            for (k = 0; k < atsd_pkg::HIST_LEN - 1; k++)
                for (a = 0; a < 3; a++)
                    hist[k][a] = hist[k+1][a];
            hist[atsd_pkg::HIST_LEN-1][0] = ax;
            hist[atsd_pkg::HIST_LEN-1][1] = ay;
            hist[atsd_pkg::HIST_LEN-1][2] = az;
            if (warm_cnt < int'(atsd_pkg::WARM_LEN)) begin
                warm_cnt++;
            end else if (refr_left > 0) begin
                refr_left--;
            end else begin
                s   = int'(thr_set);
                t   = longint'(atsd_pkg::THRESH_BASE)
                      + longint'(s) * s * longint'(atsd_pkg::THRESH_STEP);
                e   = 0;
                ptp = 0;
                for (a = 0; a < 3; a++) begin
                    // kernel -1 -2 6 -2 -1, oldest sample first
                    acc = 6 * longint'(hist[2][a]) - hist[0][a] - hist[4][a]
                          - 2 * (longint'(hist[1][a]) + hist[3][a]);
                    e += (acc * acc) >> 4;
                    lo = hist[0][a];
                    hi = lo;
                    for (k = 1; k < atsd_pkg::HIST_LEN; k++) begin
                        if (hist[k][a] < lo)
                            lo = hist[k][a];
                        if (hist[k][a] > hi)
                            hi = hist[k][a];
                    end
                    if (hi - lo > ptp)
                        ptp = hi - lo;
                end
                if (e >= (t >>> 3)) begin
                    if (cand_run < int'(atsd_pkg::RUN_MAX))
                        cand_run++;
                end else begin
                    cand_run = 0;
                end
                rep.evalid = 1'b1;
                rep.energy = (e > longint'(atsd_pkg::ENERGY_MAX)) ? atsd_pkg::ENERGY_MAX
                                                                  : e[atsd_pkg::ENERGY_BITS-1:0];
                if (e >= t && ptp >= longint'(atsd_pkg::PTP_LIMIT)
                    && cand_run <= int'(atsd_pkg::RUN_CAP)) begin
                    rep.shot = 1'b1;
                    if (shot_total != {COUNT_BITS{1'b1}})
                        shot_total++;
                    refr_left  = int'(refr_set);
                    cand_run   = 0;
                    drop_batch = !be;
                end
            end
        end
        rep.count = shot_total;
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        tap_report_t seen;
        tap_report_t want;
        if (!rst_n) begin
            for (int k = 0; k < atsd_pkg::HIST_LEN; k++)
                for (int a = 0; a < 3; a++)
                    hist[k][a] = 0;
            warm_cnt     = 0;
            refr_left    = int'(atsd_pkg::REFR_START);
            cand_run     = 0;
            drop_batch   = 1'b0;
            shot_total   = '0;
            thr_set      = THR_SET_RESET;
            refr_set     = atsd_pkg::REFR_CFG_RESET;
            mismatches   = 0;
            shot_tally   = 0;
            energy_tally = 0;
            reports_due.delete();
        end else begin
            if (out_valid && out_ready) begin
                seen.shot   = shot_detected;
                seen.count  = shot_count;
                seen.energy = energy;
                seen.evalid = energy_valid;
                if (seen.shot === 1'b1)
                    shot_tally++;
                if (seen.evalid === 1'b1)
                    energy_tally++;
                if (reports_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: shot=%0b count=%0d energy=%0d valid=%0b",
                                 seen.shot, seen.count, seen.energy, seen.evalid);
                end else begin
                    want = reports_due.pop_front();
                    if (want !== seen) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"mismatch: expected shot=%0b count=%0d energy=%0d ",
                                      "valid=%0b, got shot=%0b count=%0d energy=%0d valid=%0b"},
                                     want.shot, want.count, want.energy, want.evalid,
                                     seen.shot, seen.count, seen.energy, seen.evalid);
                    end
                end
            end
            if (in_valid && in_ready)
                reports_due.push_back(detect_tap(func, int'(accel_x), int'(accel_y),
                                                 int'(accel_z), batch_end));
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == atsd_pkg::REG_THRESHOLD)
                    thr_set = cfg_data;
                else if (cfg_index == atsd_pkg::REG_REFRACTORY)
                    refr_set = cfg_data;
            end
        end
        fail_count    <= mismatches;
        results_due   <= reports_due.size();
        shots_seen    <= shot_tally;
        energies_seen <= energy_tally;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// testbench top for the tap shot detector: clock, reset, request stimulus and verdict
module tb_top;

    localparam int SAMPLE_BITS  = 13;
    localparam int COUNT_BITS   = 20;
    localparam int IDLE_LIMIT   = 3000;
    localparam int PHASE_REQS   = 160;
    localparam int LONG_HOLD    = 300;
    localparam int LONG_VIB     = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int SAMPLE_MIN   = -(1 << (SAMPLE_BITS - 1));
    localparam int SAMPLE_MAX   = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO = SAMPLE_BITS'(SAMPLE_MIN);
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI = SAMPLE_BITS'(SAMPLE_MAX);
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic [atsd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 4'd7;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic                                func;
    logic signed [SAMPLE_BITS-1:0]       accel_x;
    logic signed [SAMPLE_BITS-1:0]       accel_y;
    logic signed [SAMPLE_BITS-1:0]       accel_z;
    logic                                batch_end;
    logic                                out_valid;
    logic                                out_ready;
    logic                                shot_detected;
    logic [COUNT_BITS-1:0]               shot_count;
    logic [atsd_pkg::ENERGY_BITS-1:0]    energy;
    logic                                energy_valid;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [atsd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [atsd_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    int fail_count;
    int results_due;
    int shots_seen;
    int energies_seen;
    int req_count;
    int clear_count;
    int idle_cycles;
    int base_x;
    int base_y;
    int base_z;
    bit calm;
    bit long_hold;
    bit hold_done;

    accel_tap_shot_detector_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .batch_end     (batch_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .shot_detected (shot_detected),
        .shot_count    (shot_count),
        .energy        (energy),
        .energy_valid  (energy_valid),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    atsd_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .batch_end     (batch_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .shot_detected (shot_detected),
        .shot_count    (shot_count),
        .energy        (energy),
        .energy_valid  (energy_valid),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .results_due   (results_due),
        .shots_seen    (shots_seen),
        .energies_seen (energies_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off
    initial
    begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (long_hold && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input int v);
        if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        else if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] raw_sample();
        bit [31:0] bits;
        bits = $urandom;
        return bits[SAMPLE_BITS-1:0];
    endfunction

    task automatic send_req(input logic f, input logic signed [SAMPLE_BITS-1:0] x,
                            input logic signed [SAMPLE_BITS-1:0] y,
                            input logic signed [SAMPLE_BITS-1:0] z, input logic be);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        accel_x   <= x;
        accel_y   <= y;
        accel_z   <= z;
        batch_end <= be;
        do @(posedge clk); while (!in_ready);
        req_count++;
        if (f == atsd_pkg::FUNC_CLEAR)
            clear_count++;
    endtask

    task automatic write_reg(input logic [atsd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [atsd_pkg::CFG_DATA_BITS-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [atsd_pkg::CFG_DATA_BITS-1:0] thr,
                                  input logic [atsd_pkg::CFG_DATA_BITS-1:0] refr,
                                  input bit poke_spare);
        if (poke_spare)
            write_reg(REG_SPARE, atsd_pkg::CFG_DATA_BITS'($urandom_range(0, 127)));
        write_reg(atsd_pkg::REG_THRESHOLD, thr);
        write_reg(atsd_pkg::REG_REFRACTORY, refr);
        cfg_valid <= 1'b0;
        base_x = jitter(1500);
        base_y = jitter(1500);
        base_z = jitter(1500);
    endtask

    // drain all outstanding results before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic quiet_run(input int n);
        repeat (n)
            send_req(FUNC_SAMPLE, clamp_sample(base_x + jitter(40)),
                     clamp_sample(base_y + jitter(40)), clamp_sample(base_z + jitter(40)),
                     $urandom_range(0, 5) == 0);
    endtask

    task automatic spike();
        int amp [3];
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                amp[a] = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1200, 4200));
                if ($urandom_range(0, 1) == 0)
                    amp[a] = -amp[a];
            end
            send_req(FUNC_SAMPLE, clamp_sample(base_x + amp[0]), clamp_sample(base_y + amp[1]),
                     clamp_sample(base_z + amp[2]), $urandom_range(0, 5) == 0);
        end
        quiet_run($urandom_range(2, 6));
    endtask

    task automatic vibration(input int n);
        int sgn;
        sgn = 1;
        repeat (n)
        begin
            send_req(FUNC_SAMPLE, clamp_sample(sgn * int'($urandom_range(800, 4200))),
                     clamp_sample(sgn * int'($urandom_range(800, 4200))),
                     clamp_sample(-sgn * int'($urandom_range(800, 4200))),
                     $urandom_range(0, 5) == 0);
            sgn = -sgn;
        end
    endtask

    task automatic run_phase(input int n_reqs);
        int start;
        start = req_count;
        while (req_count - start < n_reqs)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                    quiet_run($urandom_range(3, 12));
                8, 9, 10, 11, 12, 13, 14:
                    spike();
                15, 16:
                    vibration($urandom_range(4, 20));
                17, 18:
                    repeat ($urandom_range(1, 6))
                        send_req(FUNC_SAMPLE, raw_sample(), raw_sample(), raw_sample(),
                                 1'($urandom_range(0, 1)));
                default:
                    send_req(atsd_pkg::FUNC_CLEAR, raw_sample(), raw_sample(), raw_sample(),
                             1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_SAMPLE;
        accel_x     <= '0;
        accel_y     <= '0;
        accel_z     <= '0;
        batch_end   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= atsd_pkg::REG_THRESHOLD;
        cfg_data    <= '0;
        req_count   = 0;
        clear_count = 0;
        calm        = 1'b0;
        long_hold   = 1'b0;
        base_x      = 0;
        base_y      = 0;
        base_z      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: clear, warmup with extreme samples, refractory countdown
        send_req(atsd_pkg::FUNC_CLEAR, SAMPLE_LO, SAMPLE_HI, SAMPLE_LO, 1'b1);
        send_req(FUNC_SAMPLE, SAMPLE_LO, SAMPLE_HI, '0, 1'b0);
        send_req(FUNC_SAMPLE, SAMPLE_HI, SAMPLE_LO, SAMPLE_BITS'(-1), 1'b1);
        send_req(FUNC_SAMPLE, '0, '0, '0, 1'b0);
        send_req(FUNC_SAMPLE, SAMPLE_BITS'(-1), SAMPLE_BITS'(1), SAMPLE_LO, 1'b0);
        send_req(FUNC_SAMPLE, '0, '0, '0, 1'b1);
        repeat (int'(atsd_pkg::REFR_START))
            send_req(FUNC_SAMPLE, '0, '0, '0, 1'b0);
        // spike reaching the kernel center mid-batch, then dropped samples and a clear
        send_req(FUNC_SAMPLE, SAMPLE_BITS'(4000), SAMPLE_BITS'(-4000), SAMPLE_BITS'(4000),
                 1'b0);
        send_req(FUNC_SAMPLE, '0, '0, '0, 1'b0);
        send_req(FUNC_SAMPLE, '0, '0, '0, 1'b0);
        send_req(FUNC_SAMPLE, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, 1'b0);
        send_req(atsd_pkg::FUNC_CLEAR, '0, '0, '0, 1'b0);
        send_req(FUNC_SAMPLE, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, 1'b1);
        send_req(FUNC_SAMPLE, '0, '0, '0, 1'b1);
        settle();

        apply_settings(7'd0, 7'd2, 1'b1);
        run_phase(PHASE_REQS);
        vibration(LONG_VIB);
        settle();

        apply_settings(7'd20, 7'd0, 1'b0);
        long_hold = 1'b1;
        run_phase(PHASE_REQS);
        settle();

        apply_settings(7'd127, 7'd127, 1'b0);
        run_phase(PHASE_REQS);
        settle();

        apply_settings(7'd100, 7'd100, 1'b0);
        run_phase(PHASE_REQS);
        settle();

        apply_settings(7'd5, 7'd10, 1'b0);
        run_phase(PHASE_REQS);
        settle();

        apply_settings(7'd50, 7'd33, 1'b0);
        calm = 1'b1;
        run_phase(PHASE_REQS);
        settle();

        $display("covered %0d requests (%0d count clears) over six register settings",
                 req_count, clear_count);
        $display("with a %0d-cycle output hold-off: %0d energy results, %0d shots",
                 LONG_HOLD, energies_seen, shots_seen);
        if (fail_count == 0 && results_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/atsd_pkg.sv
rtl/atsd_axis.sv
rtl/atsd_decide.sv
rtl/accel_tap_shot_detector_core.sv
tb/atsd_checker.sv
tb/tb_top.sv
